FILE: rtl/core/dcse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcse_pkg
// Shared types and constants of the display command shadow engine.
// ----------------------------------------------------------------------------
package dcse_pkg;

  // Command kinds carried in the input tuser
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_BLINK  = 3'd2,
    OP_SHIFT  = 3'd3,
    OP_DELETE = 3'd4,
    OP_MOVE   = 3'd5,
    OP_SCROLL = 3'd6,
    OP_RESET  = 3'd7
  } op_e;

  // Configuration register indexes
  localparam int unsigned NUM_REGS   = 7;
  localparam int unsigned REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_CLEAR      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOME       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CURSOR_ON  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CURSOR_OFF = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEFT       = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ERASE      = 3'd6;

  // Character constants
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MIN   = 8'h20;
  localparam logic [7:0] CHAR_MAX   = 8'h7E;
  localparam logic [7:0] CHAR_UP_S  = 8'h53;
  localparam logic [7:0] CHAR_LO_S  = 8'h73;
  localparam logic [7:0] CHAR_FIVE  = 8'h35;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_USER_W = 2;

  // Command queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Decoded command handed from front to back
  typedef struct packed {
    op_e        kind;
    logic [7:0] ch;
    logic       ok;     // character accepted / move position not clamped
    logic [7:0] count;
    logic [7:0] pos;    // already clamped to the last digit
    logic       right;
    logic       wrap;
    logic       blink;
  } cmd_t;

  // Letter S in either case goes out as digit five
  function automatic logic [7:0] subst_s(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CHAR_UP_S || b == CHAR_LO_S) begin
      r = CHAR_FIVE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/display_command_shadow_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_command_shadow_engine
// Turns display commands into display command bytes and keeps a shadow copy
// of the displayed text and the cursor.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s_axis    in   tvalid/tready        tdata: command fields, tuser: opcode
// m_axis    out  tvalid/tready        tdata: code, tuser: flags, tlast
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// The back sequencer sends one result per cycle unless the output stalls:
// a write gives one or two, shift, delete and move up to DIGITS, scroll
// DIGITS+3, others one. A command passes through the front stage and the
// two-entry queue, then is dispatched in the back before its results.
// Reset blanks the text through per-slot valid bits, no sweep.
// A stalled output holds the sequencer; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module display_command_shadow_engine import dcse_pkg::*; #(
  parameter int DIGITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // s_axis_tdata: character[7:0], count[15:8], position[23:16],
  //               direction_right[24], wrap[25], blink_on[26], zero[31:27]
  // s_axis_tuser: opcode[2:0]
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  // m_axis_tdata: code[7:0]
  // m_axis_tuser: code_valid[0], ok[1]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [OUT_USER_W-1:0]      m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [7:0]            cfg_data_i
);

  logic front_vld;
  logic front_rdy;
  cmd_t front_cmd;
  logic q_vld;
  logic q_rdy;
  cmd_t q_cmd;

  // Command classification
  dcse_front #(
    .DIGITS (DIGITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_vld_o     (front_vld),
    .cmd_o         (front_cmd),
    .cmd_rdy_i     (front_rdy)
  );

  // Command queue
  dcse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (front_vld),
    .push_rdy_o (front_rdy),
    .push_cmd_i (front_cmd),
    .pop_vld_o  (q_vld),
    .pop_rdy_i  (q_rdy),
    .pop_cmd_o  (q_cmd)
  );

  // Command execution
  dcse_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_vld_i     (q_vld),
    .cmd_rdy_o     (q_rdy),
    .cmd_i         (q_cmd),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/core/dcse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcse_front
// Accepts command transfers, classifies them and holds one decoded command.
// ----------------------------------------------------------------------------
module dcse_front import dcse_pkg::*; #(
  parameter int DIGITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [IN_USER_W-1:0] s_axis_tuser,
  output logic                      cmd_vld_o,
  output cmd_t                      cmd_o,
  input  wire logic                 cmd_rdy_i
);

  localparam logic [7:0] POS_END  = 8'(DIGITS);
  localparam logic [7:0] POS_LAST = 8'(DIGITS - 1);

  logic       stage_vld_q;
  cmd_t       stage_q;
  cmd_t       dec;
  logic [7:0] ch;
  logic [7:0] pos;
  logic       take;

  // Field split and classification
  always_comb begin
    ch        = s_axis_tdata[7:0];
    pos       = s_axis_tdata[23:16];
    dec.kind  = op_e'(s_axis_tuser);
    dec.ch    = ch;
    dec.count = s_axis_tdata[15:8];
    dec.right = s_axis_tdata[24];
    dec.wrap  = s_axis_tdata[25];
    dec.blink = s_axis_tdata[26];
    dec.pos   = (pos >= POS_END) ? POS_LAST : pos;
    case (dec.kind)
      OP_WRITE: dec.ok = (ch >= CHAR_MIN) && (ch <= CHAR_MAX);
      OP_MOVE:  dec.ok = (pos < POS_END);
      default:  dec.ok = 1'b1;
    endcase
  end

  assign s_axis_tready = !stage_vld_q || cmd_rdy_i;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign cmd_vld_o     = stage_vld_q;
  assign cmd_o         = stage_q;

  // Decoded command stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
    end else if (take) begin
      stage_vld_q <= 1'b1;
    end else if (cmd_rdy_i) begin
      stage_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q <= dec;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dcse_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcse_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dcse_fifo import dcse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_vld_i,
  output logic      push_rdy_o,
  input  cmd_t      push_cmd_i,
  output logic      pop_vld_o,
  input  wire logic pop_rdy_i,
  output cmd_t      pop_cmd_o
);

  localparam int unsigned PW = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

  cmd_t             slots_q [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_rdy_o = (cnt_q != CNT_FULL);
  assign pop_vld_o  = (cnt_q != '0);
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;
  assign pop_cmd_o  = slots_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dcse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcse_back
// Command sequencer: shadow text, cursor, command codes and the byte output.
// ----------------------------------------------------------------------------
module dcse_back import dcse_pkg::*; #(
  parameter int DIGITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_vld_i,
  output logic                       cmd_rdy_o,
  input  cmd_t                       cmd_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [7:0]            cfg_data_i,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic [OUT_USER_W-1:0]      m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int unsigned IW = $clog2(DIGITS);
  localparam int unsigned CW = $clog2(DIGITS + 1);
  localparam logic [IW:0]   DIG_W    = (IW + 1)'(DIGITS);
  localparam logic [IW-1:0] IDX_LAST = IW'(DIGITS - 1);
  localparam logic [CW-1:0] CUR_END  = CW'(DIGITS);
  localparam logic [CW-1:0] CUR_LAST = CW'(DIGITS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_NONE,
    S_SINGLE,
    S_WR_CHAR,
    S_WR_HOME,
    S_STEP,
    S_SCR_CLR,
    S_SCR_HOME,
    S_SCR_CHAR,
    S_SCR_END
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic [7:0]        regs_q [NUM_REGS];
  logic [CW-1:0]     cursor_q;
  logic [IW-1:0]     base_q;
  logic [IW-1:0]     idx_q;
  logic [7:0]        rem_q;
  logic              right_q;
  logic              erase_q;
  logic [DIGITS-1:0] vld_q;
  logic              out_vld_q;
  logic [7:0]        out_code_q;
  logic              out_cv_q;
  logic              out_ok_q;
  logic              out_last_q;

  // Text memory, indexed by physical slot
  logic [7:0]        mem [DIGITS];
  logic [7:0]        rd_data_q;
  logic              rd_vld_q;

  logic              emit_ok;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_cv;
  logic              emit_last;
  logic              pop;
  state_e            pop_state;
  logic [7:0]        pop_rem;
  logic              pop_right;
  logic              pop_erase;
  logic [7:0]        cur8;
  logic [IW-1:0]     base_new;
  logic [IW-1:0]     blank_addr;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     cur_phys;
  logic              step_last;

  // Logical text index to physical slot, text rotates by base
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] j,
                                         input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, j} + {1'b0, b};
    if (s >= DIG_W) begin
      s = s - DIG_W;
    end
    return s[IW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign emit_ok     = !out_vld_q || m_axis_tready;
  assign pop         = (state_q == S_IDLE) && cmd_vld_i;
  assign cmd_rdy_o   = (state_q == S_IDLE);
  assign cur8        = 8'(cursor_q);
  assign cur_phys    = phys(cursor_q[IW-1:0], base_q);

  // Dispatch of a newly popped command
  always_comb begin
    pop_state  = S_NONE;
    pop_rem    = cmd_i.count;
    pop_right  = cmd_i.right;
    pop_erase  = 1'b0;
    base_new   = base_q;
    blank_addr = base_q;
    case (cmd_i.kind)
      OP_WRITE: pop_state = cmd_i.ok ? S_WR_CHAR : S_NONE;
      OP_CLEAR: pop_state = S_SINGLE;
      OP_BLINK: pop_state = S_SINGLE;
      OP_SHIFT: begin
        if (cmd_i.count != '0 &&
            (cmd_i.right ? (cursor_q < CUR_END) : (cursor_q != '0))) begin
          pop_state = S_STEP;
        end
      end
      OP_DELETE: begin
        pop_right = 1'b1;
        pop_erase = 1'b1;
        if (cmd_i.count != '0 && cursor_q < CUR_END) begin
          pop_state = S_STEP;
        end
      end
      OP_MOVE: begin
        pop_right = (cmd_i.pos > cur8);
        pop_rem   = pop_right ? (cmd_i.pos - cur8) : (cur8 - cmd_i.pos);
        if (cmd_i.pos != cur8) begin
          pop_state = S_STEP;
        end
      end
      OP_SCROLL: begin
        pop_state = S_SCR_CLR;
        if (cmd_i.right) begin
          base_new   = (base_q == '0) ? IDX_LAST : base_q - 1'b1;
          blank_addr = base_new;
        end else begin
          base_new   = (base_q == IDX_LAST) ? '0 : base_q + 1'b1;
          blank_addr = base_q;
        end
      end
      default: pop_state = S_NONE;
    endcase
  end

  // Last step of shift, delete or move
  assign step_last = (rem_q == 8'd1) ||
                     (right_q ? (cursor_q == CUR_LAST) : (cursor_q == CW'(1)));

  // Result byte of the current state
  always_comb begin
    emit      = 1'b0;
    emit_byte = '0;
    emit_cv   = 1'b1;
    emit_last = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = base_q;
    wr_en     = 1'b0;
    case (state_q)
      S_NONE: begin
        emit      = emit_ok;
        emit_cv   = 1'b0;
        emit_last = 1'b1;
      end
      S_SINGLE: begin
        emit      = emit_ok;
        emit_last = 1'b1;
        if (cmd_q.kind == OP_BLINK) begin
          emit_byte = cmd_q.blink ? regs_q[REG_CURSOR_ON] : regs_q[REG_CURSOR_OFF];
        end else begin
          emit_byte = regs_q[REG_CLEAR];
        end
      end
      S_WR_CHAR: begin
        emit      = emit_ok;
        emit_byte = cmd_q.ch;
        emit_last = (cursor_q < CUR_LAST);
        wr_en     = emit_ok && (cursor_q < CUR_END);
      end
      S_WR_HOME: begin
        emit      = emit_ok;
        emit_byte = regs_q[REG_HOME];
        emit_last = 1'b1;
      end
      S_STEP: begin
        emit      = emit_ok;
        emit_last = step_last;
        if (erase_q) begin
          emit_byte = regs_q[REG_ERASE];
        end else if (right_q) begin
          emit_byte = regs_q[REG_RIGHT];
        end else begin
          emit_byte = regs_q[REG_LEFT];
        end
      end
      S_SCR_CLR: begin
        emit      = emit_ok;
        emit_byte = regs_q[REG_CLEAR];
      end
      S_SCR_HOME: begin
        emit      = emit_ok;
        emit_byte = regs_q[REG_HOME];
        rd_en     = emit_ok;
        rd_addr   = base_q;
      end
      S_SCR_CHAR: begin
        emit      = emit_ok;
        emit_byte = rd_vld_q ? rd_data_q : CHAR_SPACE;
        rd_en     = emit_ok && (idx_q != IDX_LAST);
        rd_addr   = phys(idx_q + 1'b1, base_q);
      end
      S_SCR_END: begin
        emit      = emit_ok;
        emit_byte = regs_q[REG_HOME];
        emit_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // Sequencer, shadow state, command codes and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmd_q      <= '0;
      cursor_q   <= '0;
      base_q     <= '0;
      idx_q      <= '0;
      rem_q      <= '0;
      right_q    <= 1'b0;
      erase_q    <= 1'b0;
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      out_code_q <= '0;
      out_cv_q   <= 1'b0;
      out_ok_q   <= 1'b0;
      out_last_q <= 1'b0;
      for (int r = 0; r < NUM_REGS; r++) begin
        regs_q[r] <= '0;
      end
    end else begin
      // configuration writes, indexes past the list are dropped
      if (cfg_valid_i && (cfg_index_i < REG_IDX_W'(NUM_REGS))) begin
        regs_q[cfg_index_i] <= cfg_data_i;
      end

      // output register
      if (emit) begin
        out_vld_q  <= 1'b1;
        out_code_q <= emit_cv ? subst_s(emit_byte) : '0;
        out_cv_q   <= emit_cv;
        out_ok_q   <= cmd_q.ok;
        out_last_q <= emit_last;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      if (pop) begin
        cmd_q   <= cmd_i;
        state_q <= pop_state;
        rem_q   <= pop_rem;
        right_q <= pop_right;
        erase_q <= pop_erase;
        case (cmd_i.kind)
          OP_CLEAR: vld_q <= '0;
          OP_SCROLL: begin
            base_q <= base_new;
            if (!cmd_i.wrap) begin
              vld_q[blank_addr] <= 1'b0;
            end
          end
          OP_RESET: begin
            vld_q    <= '0;
            cursor_q <= '0;
          end
          default: vld_q <= vld_q;
        endcase
      end else if (emit) begin
        case (state_q)
          S_NONE:   state_q <= S_IDLE;
          S_SINGLE: state_q <= S_IDLE;
          S_WR_CHAR: begin
            if (cursor_q < CUR_END) begin
              vld_q[cur_phys] <= 1'b1;
            end
            if (cursor_q >= CUR_LAST) begin
              state_q <= S_WR_HOME;
            end else begin
              cursor_q <= cursor_q + 1'b1;
              state_q  <= S_IDLE;
            end
          end
          S_WR_HOME: begin
            cursor_q <= '0;
            state_q  <= S_IDLE;
          end
          S_STEP: begin
            if (erase_q) begin
              vld_q[cur_phys] <= 1'b0;
            end
            cursor_q <= right_q ? cursor_q + 1'b1 : cursor_q - 1'b1;
            rem_q    <= rem_q - 1'b1;
            if (step_last) begin
              state_q <= S_IDLE;
            end
          end
          S_SCR_CLR: state_q <= S_SCR_HOME;
          S_SCR_HOME: begin
            cursor_q <= '0;
            idx_q    <= '0;
            state_q  <= S_SCR_CHAR;
          end
          S_SCR_CHAR: begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == IDX_LAST) begin
              state_q <= S_SCR_END;
            end
          end
          S_SCR_END: state_q <= S_IDLE;
          default:   state_q <= S_IDLE;
        endcase
      end
    end
  end

  // Text memory: character writes and registered scroll reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cur_phys] <= cmd_q.ch;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = {out_ok_q, out_cv_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // cursor never passes the slot one beyond the end
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CUR_END) else $error("cursor beyond end");

  // rotation base stays inside the text
  a_base_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q <= IDX_LAST) else $error("text base out of range");

  // a result without a byte is always the only result of its command
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_cv_q) |-> out_last_q) else $error("empty result not last");

  // within a command the next result follows right after a transfer
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && m_axis_tready && !out_last_q) |=> out_vld_q)
    else $error("gap inside a command");
`endif

endmodule
`default_nettype wire

FILE: sim/display_command_shadow_engine_checker.sv
// ----------------------------------------------------------------------------
// display_command_shadow_engine_checker
// Watches the command, result and register channels of the display command
// shadow engine. It keeps its own shadow of the text, the cursor and the
// command codes, works out the bytes of every accepted command, and compares
// each result transfer field by field against the oldest pending byte.
// ----------------------------------------------------------------------------
module display_command_shadow_engine_checker import dcse_pkg::*; #(
  parameter int DIGITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  input  wire logic                  s_ready_i,
  input  wire logic [IN_DATA_W-1:0]  s_data_i,
  input  wire logic [IN_USER_W-1:0]  s_user_i,
  input  wire logic                  m_valid_i,
  input  wire logic                  m_ready_i,
  input  wire logic [OUT_DATA_W-1:0] m_data_i,
  input  wire logic [OUT_USER_W-1:0] m_user_i,
  input  wire logic                  m_last_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic                  cfg_ready_i,
  input  wire logic [REG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [7:0]            cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One byte slot on the display bus
  typedef struct packed {
    logic [7:0] code;
    logic       code_valid;
    logic       last;
    logic       ok;
  } disp_byte_t;

  logic [7:0]  code_reg [NUM_REGS];
  logic [7:0]  text_shadow [DIGITS];
  int unsigned cursor_pos;
  logic [7:0]  cmd_bytes [$];
  disp_byte_t  pending_bytes [$];

  // Letter S in either case leaves as digit five
  function automatic logic [7:0] as_sent(input logic [7:0] b);
    return (b == CHAR_UP_S || b == CHAR_LO_S) ? CHAR_FIVE : b;
  endfunction

  task automatic emit_code(input logic [7:0] b);
    cmd_bytes.push_back(as_sent(b));
  endtask

  task automatic blank_text();
    foreach (text_shadow[i]) text_shadow[i] = CHAR_SPACE;
  endtask

  // Character out, stored unless past the end, home code after the last slot
  task automatic place_char(input logic [7:0] c);
    emit_code(c);
    if (cursor_pos < DIGITS) text_shadow[cursor_pos] = c;
    if (cursor_pos >= DIGITS - 1) begin
      emit_code(code_reg[REG_HOME]);
      cursor_pos = 0;
    end else begin
      cursor_pos++;
    end
  endtask

  // Cursor steps, bounded by 0 and the slot one past the end
  task automatic step_cursor(input logic right, input int unsigned steps);
    for (int unsigned i = 0; i < steps; i++) begin
      if (right) begin
        if (cursor_pos >= DIGITS) break;
        cursor_pos++;
        emit_code(code_reg[REG_RIGHT]);
      end else begin
        if (cursor_pos == 0) break;
        cursor_pos--;
        emit_code(code_reg[REG_LEFT]);
      end
    end
  endtask

  task automatic predict_command(input logic [IN_USER_W-1:0] user,
                                 input logic [IN_DATA_W-1:0] data);
    op_e         op;
    logic [7:0]  ch;
    logic [7:0]  cnt;
    int unsigned target;
    logic        right;
    logic        wrap;
    logic        blink;
    logic        ok;
    logic [7:0]  snap [DIGITS];
    disp_byte_t  r;

    op     = op_e'(user);
    ch     = data[7:0];
    cnt    = data[15:8];
    target = 32'(data[23:16]);
    right  = data[24];
    wrap   = data[25];
    blink  = data[26];
    ok     = 1'b1;
    cmd_bytes.delete();

    case (op)
      OP_WRITE: begin
        if (ch < CHAR_MIN || ch > CHAR_MAX) ok = 1'b0;
        else place_char(ch);
      end
      OP_CLEAR: begin
        emit_code(code_reg[REG_CLEAR]);
        blank_text();
      end
      OP_BLINK: emit_code(blink ? code_reg[REG_CURSOR_ON] : code_reg[REG_CURSOR_OFF]);
      OP_SHIFT: step_cursor(right, 32'(cnt));
      OP_DELETE: begin
        for (int unsigned i = 0; i < cnt && cursor_pos < DIGITS; i++) begin
          emit_code(code_reg[REG_ERASE]);
          text_shadow[cursor_pos] = CHAR_SPACE;
          cursor_pos++;
        end
      end
      OP_MOVE: begin
        // out-of-range target is clamped to the last slot and flagged
        if (target >= DIGITS) begin
          target = DIGITS - 1;
          ok     = 1'b0;
        end
        if (target > cursor_pos) step_cursor(1'b1, target - cursor_pos);
        else if (target < cursor_pos) step_cursor(1'b0, cursor_pos - target);
      end
      OP_SCROLL: begin
        if (right) begin
          snap[0] = wrap ? text_shadow[DIGITS-1] : CHAR_SPACE;
          for (int i = 1; i < DIGITS; i++) snap[i] = text_shadow[i-1];
        end else begin
          for (int i = 0; i < DIGITS - 1; i++) snap[i] = text_shadow[i+1];
          snap[DIGITS-1] = wrap ? text_shadow[0] : CHAR_SPACE;
        end
        emit_code(code_reg[REG_CLEAR]);
        blank_text();
        emit_code(code_reg[REG_HOME]);
        cursor_pos = 0;
        for (int i = 0; i < DIGITS; i++) place_char(snap[i]);
      end
      default: begin
        blank_text();
        cursor_pos = 0;
      end
    endcase

    // a command with no byte still gives one empty slot
    if (cmd_bytes.size() == 0) begin
      r = '{code: 8'h00, code_valid: 1'b0, last: 1'b1, ok: ok};
      pending_bytes.push_back(r);
    end else begin
      foreach (cmd_bytes[k]) begin
        r = '{code: cmd_bytes[k], code_valid: 1'b1,
              last: (k == cmd_bytes.size() - 1), ok: ok};
        pending_bytes.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Results are compared before this edge's command is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    disp_byte_t exp_b;
    if (!rst_ni) begin
      foreach (code_reg[i]) code_reg[i] = 8'h00;
      blank_text();
      cursor_pos = 0;
      pending_bytes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (pending_bytes.size() == 0) begin
          $error("result transfer with nothing pending: code 0x%0h", m_data_i);
          fail_count_o++;
        end else begin
          exp_b = pending_bytes.pop_front();
          check_field("code", 32'(exp_b.code), 32'(m_data_i));
          check_field("code_valid", 32'(exp_b.code_valid), 32'(m_user_i[0]));
          check_field("ok", 32'(exp_b.ok), 32'(m_user_i[1]));
          check_field("last", 32'(exp_b.last), 32'(m_last_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_REGS) begin
        code_reg[cfg_index_i] = cfg_data_i;
      end
      if (s_valid_i && s_ready_i) predict_command(s_user_i, s_data_i);
      pending_o = pending_bytes.size();
    end
  end

endmodule

FILE: sim/tb_display_command_shadow_engine.sv
// ----------------------------------------------------------------------------
// tb_display_command_shadow_engine
// Drives commands and register writes into the display command shadow
// engine: a directed pass over field extremes and corner cases, then random
// phases under different command codes, with bursty input and a stalling
// receiver. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module tb_display_command_shadow_engine import dcse_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DIGITS      = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 26;

  logic                  clk;
  logic                  rst_n;
  logic                  s_valid;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data;
  logic [IN_USER_W-1:0]  s_user;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  logic [OUT_USER_W-1:0] m_user;
  logic                  m_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [7:0]            cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           burst_left  = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           ready_run   = 0;
  logic                  ready_level = 1'b0;

  display_command_shadow_engine #(.DIGITS(DIGITS)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  display_command_shadow_engine_checker #(.DIGITS(DIGITS)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .m_user_i     (m_user),
    .m_last_i     (m_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: long open stretches, hard stalls and short random flicker
  always @(posedge clk) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          ready_level = 1'b0;
          ready_run   = $urandom_range(1, 12);
        end
        1: begin
          ready_level = 1'b1;
          ready_run   = $urandom_range(20, 60);
        end
        default: begin
          ready_level = 1'($urandom_range(0, 1));
          ready_run   = $urandom_range(1, 4);
        end
      endcase
    end
    ready_run--;
    m_ready <= ready_level;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One command transfer; bursts of random length with random gaps between
  task automatic send_cmd(input op_e op, input logic [7:0] ch, input logic [7:0] cnt,
                          input logic [7:0] pos, input logic right,
                          input logic wrap, input logic blink);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
    end
    s_data  <= {5'b0, blink, wrap, right, pos, cnt, ch};
    s_user  <= op;
    s_valid <= 1'b1;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    burst_left--;
  endtask

  // Hold the input until every pending byte has come out
  task automatic wait_idle();
    s_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // All command codes in index order, then a write to the unused index
  task automatic program_codes(input logic [7:0] clr, input logic [7:0] home,
                               input logic [7:0] on, input logic [7:0] off,
                               input logic [7:0] rgt, input logic [7:0] lft,
                               input logic [7:0] ers);
    logic [7:0] vals [NUM_REGS+1];
    vals = '{clr, home, on, off, rgt, lft, ers, 8'($urandom)};
    for (int i = 0; i <= NUM_REGS; i++) begin
      cfg_index <= REG_IDX_W'(i);
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly printable writes and in-range moves, some rejects and clamps
  task automatic send_random_cmd();
    int unsigned pick;
    op_e         op;
    logic [7:0]  ch;
    logic [7:0]  cnt;
    logic [7:0]  pos;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_WRITE;
    else if (pick < 38) op = OP_SHIFT;
    else if (pick < 46) op = OP_DELETE;
    else if (pick < 62) op = OP_MOVE;
    else if (pick < 70) op = OP_BLINK;
    else if (pick < 80) op = OP_SCROLL;
    else if (pick < 86) op = OP_CLEAR;
    else if (pick < 90) op = OP_RESET;
    else                op = op_e'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 85)      ch = 8'($urandom_range(CHAR_MIN, CHAR_MAX));
    else if (pick < 90) ch = $urandom_range(0, 1) ? CHAR_UP_S : CHAR_LO_S;
    else                ch = 8'($urandom_range(0, 255));
    cnt = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 20))
                                     : 8'($urandom_range(0, 255));
    pos = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, DIGITS - 1))
                                      : 8'($urandom_range(0, 255));
    send_cmd(op, ch, cnt, pos, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
  endtask

  initial begin
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_user    <= OP_WRITE;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CLEAR;
    cfg_data  <= 8'h00;
    rst_n     <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // codes straight out of reset
    send_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_BLINK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
    wait_idle();

    // codes that hit the S substitution and the byte extremes
    program_codes(CHAR_UP_S, 8'h00, 8'hFF, CHAR_LO_S, 8'h52, 8'h4C, 8'h7F);

    // character range edges and rejects
    send_cmd(OP_WRITE, 8'h41, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, CHAR_UP_S, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, 8'h1F, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, 8'h7F, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, CHAR_MIN, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, CHAR_MAX, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_BLINK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    // run right into the slot past the end, then write there
    send_cmd(OP_SHIFT, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
    send_cmd(OP_WRITE, 8'h5A, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    // clamped move, then a write on the last slot wraps home
    send_cmd(OP_MOVE, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_WRITE, CHAR_LO_S, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    // shifts that give no byte
    send_cmd(OP_SHIFT, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    send_cmd(OP_SHIFT, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
    // deletes, the second one stopped by the end
    send_cmd(OP_MOVE, 8'h00, 8'h00, 8'h03, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_DELETE, 8'h00, 8'h02, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_DELETE, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
    // every scroll direction with and without wrap
    send_cmd(OP_SCROLL, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
    send_cmd(OP_SCROLL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_SCROLL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
    send_cmd(OP_SCROLL, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0);
    send_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    send_cmd(OP_RESET, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);

    // random phases, each under its own set of codes
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: program_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        1: program_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        2: program_codes(CHAR_LO_S, CHAR_UP_S, 8'($urandom), 8'($urandom),
                         CHAR_UP_S, CHAR_LO_S, 8'($urandom));
        default: program_codes(8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom));
      endcase
      repeat (PHASE_ITEMS) send_random_cmd();
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
